// ===== rtl/core/ygc_pkg.sv =====
package ygc_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned FracBits = 14;

  typedef enum logic [1:0] {
    GAMUT_BT709   = 2'd0,
    GAMUT_P3      = 2'd1,
    GAMUT_BT2100  = 2'd2,
    GAMUT_UNKNOWN = 2'd3
  } gamut_e;

  localparam logic [CfgIdxW-1:0] RegSourceGamut = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTargetGamut = 2'd1;

  typedef struct packed {
    logic [PixW-1:0] luma_top_left;
    logic [PixW-1:0] luma_top_right;
    logic [PixW-1:0] luma_bottom_left;
    logic [PixW-1:0] luma_bottom_right;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] chroma_red;
  } cell_t;

  typedef struct packed {
    logic [PixW-1:0] out_luma_top_left;
    logic [PixW-1:0] out_luma_top_right;
    logic [PixW-1:0] out_luma_bottom_left;
    logic [PixW-1:0] out_luma_bottom_right;
    logic [PixW-1:0] out_chroma_blue;
    logic [PixW-1:0] out_chroma_red;
    logic            status;
  } result_t;

  typedef struct packed {
    gamut_e source;
    gamut_e target;
  } gamut_cfg_t;

  // dY = c0*u + c1*v, Cb' = c2*u + c3*v, Cr' = c4*u + c5*v
  typedef struct packed {
    logic signed [CoefW-1:0] c0;
    logic signed [CoefW-1:0] c1;
    logic signed [CoefW-1:0] c2;
    logic signed [CoefW-1:0] c3;
    logic signed [CoefW-1:0] c4;
    logic signed [CoefW-1:0] c5;
  } coef_t;

  function automatic coef_t gamut_coefs(gamut_e src, gamut_e tgt);
    coef_t c;
    c = '0;
    unique case ({src, tgt})
      {GAMUT_BT709, GAMUT_P3}: begin
        c = {16'sd1664, 16'sd3213, 16'sd16218, -16'sd1813, -16'sd1187, 16'sd16112};
      end
      {GAMUT_BT709, GAMUT_BT2100}: begin
        c = {-16'sd278, 16'sd1578, 16'sd16307, -16'sd839, 16'sd189, 16'sd16427};
      end
      {GAMUT_P3, GAMUT_BT709}: begin
        c = {-16'sd1936, -16'sd3485, 16'sd16689, 16'sd1878, 16'sd1230, 16'sd16799};
      end
      {GAMUT_P3, GAMUT_BT2100}: begin
        c = {-16'sd2101, -16'sd1899, 16'sd16548, 16'sd1009, 16'sd1425, 16'sd16865};
      end
      {GAMUT_BT2100, GAMUT_BT709}: begin
        c = {16'sd297, -16'sd1559, 16'sd16452, 16'sd840, -16'sd189, 16'sd16331};
      end
      {GAMUT_BT2100, GAMUT_P3}: begin
        c = {16'sd1931, 16'sd1729, 16'sd16306, -16'sd976, -16'sd1378, 16'sd15999};
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ygc_cfg_regs.sv =====
module ygc_cfg_regs import ygc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output gamut_cfg_t          gamut_o
);

  gamut_cfg_t gamut_q, gamut_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gamut_d = gamut_q;
    if (cfg_valid_i) begin
      // drop writes to indexes beyond the register list
      if (cfg_index_i == RegSourceGamut) begin
        gamut_d.source = gamut_e'(cfg_data_i);
      end else if (cfg_index_i == RegTargetGamut) begin
        gamut_d.target = gamut_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamut_q <= '{source: GAMUT_BT709, target: GAMUT_BT709};
    end else begin
      gamut_q <= gamut_d;
    end
  end

  assign gamut_o = gamut_q;

endmodule

// ===== rtl/core/ygc_convert.sv =====
module ygc_convert import ygc_pkg::*; (
  input  cell_t      cell_i,
  input  gamut_cfg_t gamut_i,
  output result_t    res_o
);

  localparam int unsigned ProdW = PixW + CoefW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned RndW  = SumW - FracBits;
  localparam int unsigned WideW = RndW + 1;

  coef_t                   coef;
  logic signed [PixW-1:0]  u, v;
  logic signed [ProdW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [SumW-1:0]  dy_sum, nu_sum, nv_sum;
  logic signed [RndW-1:0]  dy, nu, nv;
  logic                    unknown, bypass;

  function automatic logic [PixW-1:0] clamp_u8(logic signed [WideW-1:0] x);
    logic [PixW-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > WideW'(255)) begin
      r = '1;
    end else begin
      r = x[PixW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [RndW-1:0] q14_round(logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] b;
    b = x + SumW'(1 << (FracBits - 1));
    return RndW'(b >>> FracBits);
  endfunction

  assign coef = gamut_coefs(gamut_i.source, gamut_i.target);

  // flipping the top bit removes the chroma offset of 128
  assign u = signed'(cell_i.chroma_blue ^ 8'h80);
  assign v = signed'(cell_i.chroma_red ^ 8'h80);

  assign p0 = coef.c0 * u;
  assign p1 = coef.c1 * v;
  assign p2 = coef.c2 * u;
  assign p3 = coef.c3 * v;
  assign p4 = coef.c4 * u;
  assign p5 = coef.c5 * v;

  assign dy_sum = SumW'(p0) + SumW'(p1);
  assign nu_sum = SumW'(p2) + SumW'(p3);
  assign nv_sum = SumW'(p4) + SumW'(p5);

  assign dy = q14_round(dy_sum);
  assign nu = q14_round(nu_sum);
  assign nv = q14_round(nv_sum);

  assign unknown = (gamut_i.source == GAMUT_UNKNOWN) || (gamut_i.target == GAMUT_UNKNOWN);
  assign bypass  = unknown || (gamut_i.source == gamut_i.target);

  always_comb begin
    if (bypass) begin
      res_o.out_luma_top_left     = cell_i.luma_top_left;
      res_o.out_luma_top_right    = cell_i.luma_top_right;
      res_o.out_luma_bottom_left  = cell_i.luma_bottom_left;
      res_o.out_luma_bottom_right = cell_i.luma_bottom_right;
      res_o.out_chroma_blue       = cell_i.chroma_blue;
      res_o.out_chroma_red        = cell_i.chroma_red;
    end else begin
      res_o.out_luma_top_left =
        clamp_u8(signed'(WideW'(cell_i.luma_top_left)) + WideW'(dy));
      res_o.out_luma_top_right =
        clamp_u8(signed'(WideW'(cell_i.luma_top_right)) + WideW'(dy));
      res_o.out_luma_bottom_left =
        clamp_u8(signed'(WideW'(cell_i.luma_bottom_left)) + WideW'(dy));
      res_o.out_luma_bottom_right =
        clamp_u8(signed'(WideW'(cell_i.luma_bottom_right)) + WideW'(dy));
      res_o.out_chroma_blue = clamp_u8(WideW'(nu) + signed'(WideW'(128)));
      res_o.out_chroma_red  = clamp_u8(WideW'(nv) + signed'(WideW'(128)));
    end
    res_o.status = unknown;
  end

endmodule

// ===== rtl/core/yuv420_gamut_convert_top.sv =====
// Converts one 4:2:0 cell (four lumas and a shared Cb/Cr pair) per clock between
// BT.709, Display P3 (601 matrix) and BT.2100 YUV. A request is taken at every edge
// with start high; busy never rises. The result appears on res_o with done_o high
// for exactly one cycle, after the request passes the input register and then the
// Q14 matrix, rounding and clamp into the result register. The receiver cannot
// stall, so results must be taken when shown.
// Write source_gamut (index 0) and target_gamut (index 1) only while no request
// is in flight; code 3 passes the cell unchanged and sets status.
module yuv420_gamut_convert_top import ygc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cell_t               cmd_i,
  output logic                done_o,
  output result_t             res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  gamut_cfg_t gamut;
  cell_t      cell_q;
  logic       vld_q;
  result_t    res_d, res_q;
  logic       done_q;

  assign busy = 1'b0;

  ygc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gamut_o     (gamut)
  );

  ygc_convert u_convert (
    .cell_i  (cell_q),
    .gamut_i (gamut),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start && !busy;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cell_q <= cmd_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/ygc_checker.sv =====
module ygc_checker import ygc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cell_t   cmd_i,
  input logic    done_o,
  input result_t res_o
);

  // every accepted request yields a result once it has passed the input and result registers
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("accepted request produced no result");

  // no result without a request behind it
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // an unrecognized gamut passes the cell through unchanged
  a_status_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status |->
      res_o.out_luma_top_left == $past(cmd_i.luma_top_left, 2) &&
      res_o.out_luma_top_right == $past(cmd_i.luma_top_right, 2) &&
      res_o.out_luma_bottom_left == $past(cmd_i.luma_bottom_left, 2) &&
      res_o.out_luma_bottom_right == $past(cmd_i.luma_bottom_right, 2) &&
      res_o.out_chroma_blue == $past(cmd_i.chroma_blue, 2) &&
      res_o.out_chroma_red == $past(cmd_i.chroma_red, 2))
    else $error("status set but cell was altered");

endmodule

bind yuv420_gamut_convert_top ygc_checker u_ygc_checker (.*);
